// ----- rtl/qlod_pkg.sv -----
// Package for the quadtree LOD selection block.
// Types, register codes and helper functions shared by all rtl files.
// No dependencies.
package qlod_pkg;

  localparam int MAX_LEVELS = 4;

  localparam int COORD_W = 25;
  localparam int MAG_W   = 25;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int THR_W   = 48;
  localparam int ACC_W   = 52;
  localparam int SCL_W   = 56;
  localparam int IDX_W   = 7;
  localparam int LVL_W   = 2;

  typedef enum logic [1:0] {
    CFG_LEVEL_COUNT  = 2'd0,
    CFG_TERRAIN_SIZE = 2'd1,
    CFG_MAX_DISTANCE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [23:0] view_tx;
    logic signed [23:0] view_ty;
    logic signed [23:0] view_tz;
  } view_t;

  typedef struct packed {
    logic [6:0] node_index;
    logic [1:0] node_level;
    logic       last_node;
  } node_t;

  typedef struct packed {
    logic [2:0]  level_count;
    logic [15:0] terrain_size;
    logic [23:0] max_distance;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_THR,
    S_DY,
    S_DYW,
    S_DX,
    S_DZ,
    S_SUM,
    S_CMP,
    S_EMIT,
    S_UP
  } seq_state_t;

  // The walk ends after a node whose path from the root takes the last child at every level.
  function automatic logic is_last(input logic [IDX_W-1:0] idx);
    return (idx == 7'd0) || (idx == 7'd4) || (idx == 7'd20) || (idx == 7'd84);
  endfunction

  function automatic logic [2:0] clamp_levels(input logic [2:0] lc);
    logic [2:0] lim;
    lim = lc;
    if (lc == 3'd0) lim = 3'd1;
    else if (lc > 3'(MAX_LEVELS)) lim = 3'(MAX_LEVELS);
    return lim;
  endfunction

  // Child offset at a level: floor(size / 2^level) world units, in Q16.8.
  function automatic logic [COORD_W-1:0] level_offset(input logic [15:0] size,
                                                     input logic [LVL_W-1:0] lvl);
    logic [15:0] s;
    s = size >> lvl;
    return {1'b0, s, 8'd0};
  endfunction

endpackage

// ----- rtl/qlod_stream_if.sv -----
// Valid/ready stream interfaces for view input and node output.
// Depends on qlod_pkg for the payload types.
interface qlod_view_if;
  import qlod_pkg::*;
  logic  valid;
  logic  ready;
  view_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qlod_node_if;
  import qlod_pkg::*;
  logic  valid;
  logic  ready;
  node_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/qlod_mul.sv -----
// Shared unsigned multiplier with registered product.
// Depends on qlod_pkg for operand widths.
module qlod_mul (
  input  logic                        clk,
  input  logic [qlod_pkg::MAG_W-1:0]  a,
  input  logic [qlod_pkg::MAG_W-1:0]  b,
  output logic [qlod_pkg::PROD_W-1:0] p
);
  import qlod_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- rtl/qlod_seq.sv -----
// Walk sequencer: tree traversal, distance accumulation and refine decision.
// Depends on qlod_pkg, qlod_view_if; drives the shared multiplier.
module qlod_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  qlod_pkg::cfg_t              cfg,
  qlod_view_if.sink                   view,
  output logic [qlod_pkg::MAG_W-1:0]  mul_a,
  output logic [qlod_pkg::MAG_W-1:0]  mul_b,
  input  logic [qlod_pkg::PROD_W-1:0] mul_p,
  output logic                        res_valid,
  output qlod_pkg::node_t             res,
  input  logic                        res_ready
);
  import qlod_pkg::*;

  seq_state_t state, state_next;

  logic signed [COORD_W-1:0] cam_x, cam_y, cam_z, nx, nz;
  logic [IDX_W-1:0]          idx;
  logic [LVL_W-1:0]          level;
  logic [THR_W-1:0]          thr;
  logic [THR_W-1:0]          dy2;
  logic [ACC_W-1:0]          acc;

  logic [2:0]                lim;
  logic signed [COORD_W:0]   dx, dz;
  logic [MAG_W-1:0]          dx_mag, dz_mag, dy_mag;
  logic [SCL_W-1:0]          scaled;
  logic                      refine, descend, last;
  logic [LVL_W-1:0]          off_lvl;
  logic [COORD_W-1:0]        off;
  logic [1:0]                digit;
  logic [IDX_W-1:0]          idx_m1;

  assign lim     = clamp_levels(cfg.level_count);
  assign dx      = $signed({cam_x[COORD_W-1], cam_x}) - $signed({nx[COORD_W-1], nx});
  assign dz      = $signed({cam_z[COORD_W-1], cam_z}) - $signed({nz[COORD_W-1], nz});
  assign dx_mag  = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
  assign dz_mag  = dz[COORD_W] ? MAG_W'(-dz) : MAG_W'(dz);
  assign dy_mag  = cam_y[COORD_W-1] ? MAG_W'(-cam_y) : MAG_W'(cam_y);
  assign last    = is_last(idx);
  assign idx_m1  = idx - 7'd1;
  assign digit   = idx_m1[1:0];
  assign off_lvl = (state == S_CMP) ? LVL_W'(level + 2'd1) : level;
  assign off     = level_offset(cfg.terrain_size, off_lvl);

  always_comb begin
    case (level)
      2'd0:    scaled = SCL_W'(acc);
      2'd1:    scaled = SCL_W'(acc) << 2;
      2'd2:    scaled = (SCL_W'(acc) << 3) + SCL_W'(acc);
      default: scaled = SCL_W'(acc) << 4;
    endcase
  end

  assign refine  = scaled < SCL_W'(thr);
  assign descend = refine && ((3'(level) + 3'd1) < lim);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (view.valid) state_next = S_THR;
      S_THR:   state_next = S_DY;
      S_DY:    state_next = S_DYW;
      S_DYW:   state_next = S_DX;
      S_DX:    state_next = S_DZ;
      S_DZ:    state_next = S_SUM;
      S_SUM:   state_next = S_CMP;
      S_CMP:   state_next = descend ? S_DX : S_EMIT;
      S_EMIT: begin
        if (res_ready) state_next = last ? S_IDLE : S_UP;
      end
      S_UP:    if (digit != 2'd3) state_next = S_DX;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    view.ready = 1'b0;
    res_valid  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: view.ready = 1'b1;
      S_THR: begin
        mul_a = MAG_W'(cfg.max_distance);
        mul_b = MAG_W'(cfg.max_distance);
      end
      S_DY: begin
        mul_a = dy_mag;
        mul_b = dy_mag;
      end
      S_DX: begin
        mul_a = dx_mag;
        mul_b = dx_mag;
      end
      S_DZ: begin
        mul_a = dz_mag;
        mul_b = dz_mag;
      end
      S_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.node_index = idx;
  assign res.node_level = level;
  assign res.last_node  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cam_x <= COORD_W'(0) - COORD_W'(view.data.view_tx);
        cam_y <= COORD_W'(0) - COORD_W'(view.data.view_ty);
        cam_z <= COORD_W'(0) - COORD_W'(view.data.view_tz);
        nx    <= '0;
        nz    <= '0;
        idx   <= '0;
        level <= '0;
      end
      S_DY:  thr <= mul_p[THR_W-1:0];
      S_DYW: dy2 <= mul_p[THR_W-1:0];
      S_DZ:  acc <= ACC_W'(dy2) + ACC_W'(mul_p);
      S_SUM: acc <= acc + ACC_W'(mul_p);
      S_CMP: begin
        if (descend) begin
          level <= LVL_W'(level + 2'd1);
          idx   <= IDX_W'({idx, 2'b00} + 9'd1);
          nx    <= nx + $signed(off);
          nz    <= nz - $signed(off);
        end
      end
      S_UP: begin
        case (digit)
          2'd0: begin
            idx <= idx + 7'd1;
            nx  <= nx - $signed(off << 1);
          end
          2'd1: begin
            idx <= idx + 7'd1;
            nx  <= nx + $signed(off << 1);
            nz  <= nz + $signed(off << 1);
          end
          2'd2: begin
            idx <= idx + 7'd1;
            nx  <= nx - $signed(off << 1);
          end
          default: begin
            idx   <= {2'b00, idx_m1[IDX_W-1:2]};
            level <= LVL_W'(level - 2'd1);
            nx    <= nx + $signed(off);
            nz    <= nz - $signed(off);
          end
        endcase
      end
      default: ;
    endcase
  end

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last_node |=> state == S_IDLE)
    else $error("walk did not end after last node");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> (3'(level) < lim))
    else $error("walk level beyond level count");

  a_root_index: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && level == 2'd0 |-> idx == '0)
    else $error("root level with nonzero index");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    view.valid && view.ready |=> state == S_THR)
    else $error("transfer did not start a walk");

endmodule

// ----- rtl/quadtree_lod_select_core.sv -----
// Top level of quadtree LOD selection: config registers, walk sequencer,
// shared multiplier and output register.
// Depends on qlod_pkg, qlod_stream_if, qlod_mul, qlod_seq.
//
//   channel  dir  payload                           transfer
//   view     in   view_tx, view_ty, view_tz         valid & ready
//   lod      out  node_index, node_level, last_node valid & ready
//   cfg      in   cfg_index, cfg_data               cfg_we
//
// After its transfer a view runs the setup steps S_THR, S_DY and S_DYW, which
// square the maximum distance and the height; each visited node then takes
// S_DX, S_DZ, S_SUM and S_CMP, each shown node S_EMIT and each move to a
// sibling or a parent S_UP. The shared multiplier squares the terms one at a time.
// Reset is synchronous and returns to idle with register defaults.
// A stalled output holds the walk in its emit step; view is taken only when idle.
module quadtree_lod_select_core (
  input  logic        clk,
  input  logic        rst,
  qlod_view_if.sink   view,
  qlod_node_if.source lod,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import qlod_pkg::*;

  cfg_t              cfg;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              res_valid, res_ready;
  node_t             res;
  logic              out_valid;
  node_t             out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_count  <= 3'd4;
      cfg.terrain_size <= 16'd1024;
      cfg.max_distance <= 24'd256000;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LEVEL_COUNT:  cfg.level_count  <= cfg_data[2:0];
        CFG_TERRAIN_SIZE: cfg.terrain_size <= cfg_data[15:0];
        CFG_MAX_DISTANCE: cfg.max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  qlod_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  qlod_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .view      (view),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || lod.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign lod.valid = out_valid;
  assign lod.data  = out_data;

endmodule
